@@ design/c2ifm_pkg.sv @@
// Shared types and codes for the two-wire debug interface frame master.
package c2ifm_pkg;

  localparam int unsigned CfgIndexW = 1;
  localparam int unsigned CfgDataW  = 8;

  // Command codes carried in mode
  localparam logic [2:0] MODE_NONE     = 3'd0;
  localparam logic [2:0] MODE_AR_READ  = 3'd1;
  localparam logic [2:0] MODE_AR_WRITE = 3'd2;
  localparam logic [2:0] MODE_DR_READ  = 3'd3;
  localparam logic [2:0] MODE_DR_WRITE = 3'd4;
  localparam logic [2:0] MODE_RESET    = 3'd5;

  // Clock actions
  localparam logic [1:0] CLK_IDLE  = 2'd0;
  localparam logic [1:0] CLK_PULSE = 2'd1;
  localparam logic [1:0] CLK_LOW   = 2'd2;

  // Register indexes
  localparam logic [CfgIndexW-1:0] REG_RESET_LOW    = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_RESET_SETTLE = 1'b1;

  localparam logic [7:0] RESET_LOW_DEFAULT    = 8'd20;
  localparam logic [7:0] RESET_SETTLE_DEFAULT = 8'd2;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_in;
    logic       line_sample;
  } item_t;

  typedef struct packed {
    logic [1:0] clock_action;
    logic       line_enable;
    logic       line_level;
    logic       frame_done;
    logic [7:0] read_byte;
    logic       busy_res;
  } result_t;

  typedef struct packed {
    logic [7:0] reset_low_slots;
    logic [7:0] reset_settle_slots;
  } cfg_t;

endpackage

@@ design/c2ifm_fsm.sv @@
// Frame sequencer: slot state machine with the registered result of each slot.
module c2ifm_fsm (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  c2ifm_pkg::item_t  item,
  input  c2ifm_pkg::cfg_t   cfg,
  output c2ifm_pkg::result_t res
);

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_INS   = 4'd1,
    PH_LEN   = 4'd2,
    PH_WDATA = 4'd3,
    PH_RDATA = 4'd4,
    PH_WAIT  = 4'd5,
    PH_STOP  = 4'd6,
    PH_RLOW  = 4'd7,
    PH_RHIGH = 4'd8
  } phase_t;

  phase_t     phase, phase_next;
  logic [2:0] frame_kind, frame_kind_next;
  logic [3:0] bit_count, bit_count_next;
  logic [7:0] shift_byte, shift_byte_next;
  logic       sample_pending, sample_pending_next;
  logic [7:0] reset_timer, reset_timer_next;
  c2ifm_pkg::result_t res_next;

  logic [3:0] bc_inc;
  logic [7:0] sampled;
  logic [7:0] timer_dec;
  logic [7:0] low_first;
  logic [7:0] settle_load;
  logic [1:0] ins_code;
  logic       is_read;

  assign bc_inc      = bit_count + 4'd1;
  assign sampled     = sample_pending ? {item.line_sample, shift_byte[7:1]} : shift_byte;
  assign timer_dec   = (reset_timer != 8'd0) ? reset_timer - 8'd1 : reset_timer;
  assign low_first   = (cfg.reset_low_slots == 8'd0) ? 8'd0 : cfg.reset_low_slots - 8'd1;
  assign settle_load = (cfg.reset_settle_slots == 8'd0) ? 8'd1 : cfg.reset_settle_slots;
  assign is_read     = (frame_kind == c2ifm_pkg::MODE_AR_READ) ||
                       (frame_kind == c2ifm_pkg::MODE_DR_READ);

  always_comb begin
    case (frame_kind)
      c2ifm_pkg::MODE_AR_READ:  ins_code = 2'd2;
      c2ifm_pkg::MODE_AR_WRITE: ins_code = 2'd3;
      c2ifm_pkg::MODE_DR_WRITE: ins_code = 2'd1;
      default:                  ins_code = 2'd0;
    endcase
  end

  always_comb begin
    phase_next          = phase;
    frame_kind_next     = frame_kind;
    bit_count_next      = bit_count;
    shift_byte_next     = shift_byte;
    sample_pending_next = sample_pending;
    reset_timer_next    = reset_timer;
    res_next            = '0;
    res_next.clock_action = c2ifm_pkg::CLK_IDLE;

    case (phase)
      PH_IDLE: begin
        if (item.mode inside {[c2ifm_pkg::MODE_AR_READ:c2ifm_pkg::MODE_DR_WRITE]}) begin
          frame_kind_next     = item.mode;
          shift_byte_next     = (item.mode == c2ifm_pkg::MODE_AR_WRITE ||
                                 item.mode == c2ifm_pkg::MODE_DR_WRITE) ? item.data_in : 8'd0;
          sample_pending_next = 1'b0;
          bit_count_next      = 4'd0;
          res_next.clock_action = c2ifm_pkg::CLK_PULSE;
          res_next.line_enable  = 1'b1;
          phase_next          = PH_INS;
        end else if (item.mode == c2ifm_pkg::MODE_RESET) begin
          frame_kind_next       = c2ifm_pkg::MODE_RESET;
          res_next.clock_action = c2ifm_pkg::CLK_LOW;
          if (low_first == 8'd0) begin
            reset_timer_next = settle_load;
            phase_next       = PH_RHIGH;
          end else begin
            reset_timer_next = low_first;
            phase_next       = PH_RLOW;
          end
        end
      end
      PH_INS: begin
        res_next.clock_action = c2ifm_pkg::CLK_PULSE;
        res_next.line_enable  = 1'b1;
        res_next.line_level   = bit_count[0] ? ins_code[1] : ins_code[0];
        bit_count_next        = bc_inc;
        if (bc_inc >= 4'd2) begin
          bit_count_next = 4'd0;
          if (frame_kind == c2ifm_pkg::MODE_AR_READ) begin
            phase_next = PH_RDATA;
          end else if (frame_kind == c2ifm_pkg::MODE_AR_WRITE) begin
            phase_next = PH_WDATA;
          end else begin
            phase_next = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        res_next.clock_action = c2ifm_pkg::CLK_PULSE;
        res_next.line_enable  = 1'b1;
        bit_count_next        = bc_inc;
        if (bc_inc >= 4'd2) begin
          bit_count_next      = 4'd0;
          sample_pending_next = 1'b0;
          phase_next = (frame_kind == c2ifm_pkg::MODE_DR_WRITE) ? PH_WDATA : PH_WAIT;
        end
      end
      PH_WDATA: begin
        res_next.clock_action = c2ifm_pkg::CLK_PULSE;
        res_next.line_enable  = 1'b1;
        res_next.line_level   = shift_byte[0];
        shift_byte_next       = {1'b0, shift_byte[7:1]};
        bit_count_next        = bc_inc;
        if (bc_inc >= 4'd8) begin
          bit_count_next      = 4'd0;
          sample_pending_next = 1'b0;
          phase_next = (frame_kind == c2ifm_pkg::MODE_DR_WRITE) ? PH_WAIT : PH_STOP;
        end
      end
      PH_WAIT: begin
        if (sample_pending && item.line_sample) begin
          if (frame_kind == c2ifm_pkg::MODE_DR_READ) begin
            shift_byte_next       = 8'd0;
            res_next.clock_action = c2ifm_pkg::CLK_PULSE;
            sample_pending_next   = 1'b1;
            bit_count_next        = 4'd1;
            phase_next            = PH_RDATA;
          end else begin
            // ready seen on a write: this slot is the stop slot
            res_next.clock_action = c2ifm_pkg::CLK_PULSE;
            res_next.line_enable  = 1'b1;
            res_next.frame_done   = 1'b1;
            res_next.read_byte    = is_read ? shift_byte : 8'd0;
            sample_pending_next   = 1'b0;
            bit_count_next        = 4'd0;
            phase_next            = PH_IDLE;
          end
        end else begin
          res_next.clock_action = c2ifm_pkg::CLK_PULSE;
          sample_pending_next   = 1'b1;
        end
      end
      PH_RDATA: begin
        shift_byte_next       = sampled;
        res_next.clock_action = c2ifm_pkg::CLK_PULSE;
        sample_pending_next   = 1'b1;
        bit_count_next        = bc_inc;
        if (bc_inc >= 4'd8) begin
          bit_count_next = 4'd0;
          phase_next     = PH_STOP;
        end
      end
      PH_STOP: begin
        shift_byte_next       = sampled;
        res_next.clock_action = c2ifm_pkg::CLK_PULSE;
        res_next.line_enable  = 1'b1;
        res_next.frame_done   = 1'b1;
        res_next.read_byte    = is_read ? sampled : 8'd0;
        sample_pending_next   = 1'b0;
        bit_count_next        = 4'd0;
        phase_next            = PH_IDLE;
      end
      PH_RLOW: begin
        res_next.clock_action = c2ifm_pkg::CLK_LOW;
        reset_timer_next      = timer_dec;
        if (timer_dec == 8'd0) begin
          reset_timer_next = settle_load;
          phase_next       = PH_RHIGH;
        end
      end
      PH_RHIGH: begin
        reset_timer_next = timer_dec;
        if (timer_dec == 8'd0) begin
          res_next.frame_done = 1'b1;
          phase_next          = PH_IDLE;
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    res_next.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      frame_kind     <= c2ifm_pkg::MODE_NONE;
      bit_count      <= 4'd0;
      shift_byte     <= 8'd0;
      sample_pending <= 1'b0;
      reset_timer    <= 8'd0;
      res            <= '0;
    end else if (step) begin
      phase          <= phase_next;
      frame_kind     <= frame_kind_next;
      bit_count      <= bit_count_next;
      shift_byte     <= shift_byte_next;
      sample_pending <= sample_pending_next;
      reset_timer    <= reset_timer_next;
      res            <= res_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    res.busy_res == (phase != PH_IDLE))
    else $error("busy flag out of step with sequencer phase");

  assert property (@(posedge clk) disable iff (rst)
    (res.read_byte != 8'd0) |-> res.frame_done)
    else $error("read byte shown outside a frame end");

  assert property (@(posedge clk) disable iff (rst)
    (res.clock_action == c2ifm_pkg::CLK_LOW) |-> (!res.line_enable && frame_kind ==
      c2ifm_pkg::MODE_RESET))
    else $error("clock held low outside a target reset");

  assert property (@(posedge clk) disable iff (rst)
    (phase == PH_INS || phase == PH_LEN) |-> (bit_count < 4'd2))
    else $error("header bit count overrun");

endmodule

@@ design/c2_interface_frame_master.sv @@
// Top level of the two-wire debug interface frame master.
// A slot beat is held in the input stage register, and its result in the result register.
// Throughput: one slot per clock unless a result waits on res_ready.
// Stage and result register advance together; the stage refills while a result is taken.
// Reset: sequencer idle, reset_low_slots = 20, reset_settle_slots = 2, no beats held.
module c2_interface_frame_master (
  input  logic       clk,
  input  logic       rst,

  input  logic       item_valid,
  output logic       item_ready,
  input  logic [2:0] mode,
  input  logic [7:0] data_in,
  input  logic       line_sample,

  output logic       res_valid,
  input  logic       res_ready,
  output logic [1:0] clock_action,
  output logic       line_enable,
  output logic       line_level,
  output logic       frame_done,
  output logic [7:0] read_byte,
  output logic       busy_res,

  input  logic                                cfg_we,
  input  logic [c2ifm_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [c2ifm_pkg::CfgDataW-1:0]      cfg_data
);

  c2ifm_pkg::cfg_t    cfg;
  c2ifm_pkg::item_t   stage;
  c2ifm_pkg::result_t res;
  logic               stage_valid;
  logic               step;

  assign step       = stage_valid && (!res_valid || res_ready);
  assign item_ready = !stage_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reset_low_slots    <= c2ifm_pkg::RESET_LOW_DEFAULT;
      cfg.reset_settle_slots <= c2ifm_pkg::RESET_SETTLE_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_index)
        c2ifm_pkg::REG_RESET_LOW:    cfg.reset_low_slots    <= cfg_data;
        c2ifm_pkg::REG_RESET_SETTLE: cfg.reset_settle_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage.mode        <= mode;
      stage.data_in     <= data_in;
      stage.line_sample <= line_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  c2ifm_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .item (stage),
    .cfg  (cfg),
    .res  (res)
  );

  assign clock_action = res.clock_action;
  assign line_enable  = res.line_enable;
  assign line_level   = res.line_level;
  assign frame_done   = res.frame_done;
  assign read_byte    = res.read_byte;
  assign busy_res     = res.busy_res;

endmodule
